// ===== hw/rtl/quadratic_midpoint_curve_gen_core_defines.svh =====
// assertion macros shared by the curve generator rtl
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef QUADRATIC_MIDPOINT_CURVE_GEN_CORE_DEFINES_SVH
`define QUADRATIC_MIDPOINT_CURVE_GEN_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define QMCG_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qmcg assertion failed");
`define QMCG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qmcg assertion failed");
`else
`define QMCG_ASSERT_IMPL(name, clk, rst, ante, cons)
`define QMCG_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/qmcg_pkg.sv =====
// shared types and constants of the quadratic midpoint curve generator
// no dependencies
`default_nettype none

package qmcg_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int MAX_DENSITY_DEF = 64;
   localparam int DENSITY_WIDTH = 7;
   localparam logic [DENSITY_WIDTH-1:0] DENSITY_RESET = 7'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WEIGHT,
      ST_MULT,
      ST_SUM,
      ST_PREP,
      ST_DIV,
      ST_OUT
   } qmcg_state_type;

   typedef enum logic [1:0] {
      PTS_NONE,
      PTS_ONE,
      PTS_TWO
   } qmcg_points_type;

   typedef struct packed {
      logic start;
      logic a_from_input;
      logic line;
      logic c_from_input;
      logic start_from_input;
      logic start_from_mid;
      logic [DENSITY_WIDTH-1:0] density;
      logic [DENSITY_WIDTH-1:0] j;
      logic weight_en;
      logic mult_en;
      logic sum_en;
      logic prep_en;
      logic div_en;
      logic out_load;
      logic run_end;
      logic path_end;
   } qmcg_cmd_type;

   typedef struct packed {
      logic out_free;
   } qmcg_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/qmcg_req_if.sv =====
// control point channel of the curve generator
// depends on qmcg_pkg
`default_nettype none

interface qmcg_req_if #(
   parameter int COORD_WIDTH = qmcg_pkg::COORD_WIDTH_DEF
) ();
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] in_x;
   logic signed [COORD_WIDTH-1:0] in_y;
   logic path_final;

   modport source (output valid, output in_x, output in_y, output path_final, input ready);
   modport sink (input valid, input in_x, input in_y, input path_final, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/qmcg_rsp_if.sv =====
// curve sample channel of the curve generator
// depends on qmcg_pkg
`default_nettype none

interface qmcg_rsp_if #(
   parameter int COORD_WIDTH = qmcg_pkg::COORD_WIDTH_DEF
) ();
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic run_end;
   logic path_end;

   modport source (output valid, output out_x, output out_y, output run_end, output path_end,
                   input ready);
   modport sink (input valid, input out_x, input out_y, input run_end, input path_end,
                 output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/qmcg_csr_if.sv =====
// density register write channel of the curve generator
// depends on qmcg_pkg
`default_nettype none

interface qmcg_csr_if ();
   logic valid;
   logic ready;
   logic [qmcg_pkg::DENSITY_WIDTH-1:0] segment_density;

   modport source (output valid, output segment_density, input ready);
   modport sink (input valid, input segment_density, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/qmcg_ctrl.sv =====
// controller: path tracking, density register and per-sample sequencing
// depends on qmcg_pkg and the assertion macro header
`default_nettype none
`include "quadratic_midpoint_curve_gen_core_defines.svh"

module qmcg_ctrl #(
   parameter int COORD_WIDTH = qmcg_pkg::COORD_WIDTH_DEF,
   parameter int MAX_DENSITY = qmcg_pkg::MAX_DENSITY_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_final,
   output logic req_ready,
   input  logic csr_valid,
   input  logic [qmcg_pkg::DENSITY_WIDTH-1:0] csr_data,
   output logic csr_ready,
   input  qmcg_pkg::qmcg_status_type status,
   output qmcg_pkg::qmcg_cmd_type cmd
);

   localparam int DNW = qmcg_pkg::DENSITY_WIDTH;
   localparam int CNT_W = $clog2(COORD_WIDTH);
   localparam logic [DNW-1:0] DMAX = DNW'(MAX_DENSITY);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COORD_WIDTH - 1);

   qmcg_pkg::qmcg_state_type state_ff, state_in;
   qmcg_pkg::qmcg_points_type points_ff, points_in;
   logic [DNW-1:0] density_ff;
   logic [DNW-1:0] j_ff, j_in;
   logic [DNW-1:0] last_j_ff, last_j_in;
   logic fin_ff, fin_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DNW-1:0] dens;
   logic last_sample;

   assign csr_ready = 1'b1;

   always_comb begin
      if (density_ff == '0) begin
         dens = DNW'(1);
      end else if (density_ff > DMAX) begin
         dens = DMAX;
      end else begin
         dens = density_ff;
      end
   end

   assign last_sample = (j_ff == last_j_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qmcg_pkg::ST_IDLE;
         points_ff <= qmcg_pkg::PTS_NONE;
         density_ff <= qmcg_pkg::DENSITY_RESET;
         j_ff <= '0;
         last_j_ff <= '0;
         fin_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         points_ff <= points_in;
         j_ff <= j_in;
         last_j_ff <= last_j_in;
         fin_ff <= fin_in;
         cnt_ff <= cnt_in;
         if (csr_valid) begin
            density_ff <= csr_data;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      points_in = points_ff;
      j_in = j_ff;
      last_j_in = last_j_ff;
      fin_in = fin_ff;
      cnt_in = cnt_ff;
      req_ready = 1'b0;
      cmd = '0;
      cmd.density = dens;
      cmd.j = j_ff;
      unique case (state_ff)
         qmcg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               cmd.a_from_input = (points_ff == qmcg_pkg::PTS_NONE);
               cmd.line = (points_ff == qmcg_pkg::PTS_ONE);
               cmd.c_from_input = req_final;
               cmd.start_from_input = (points_ff == qmcg_pkg::PTS_NONE) && !req_final;
               cmd.start_from_mid = (points_ff == qmcg_pkg::PTS_TWO) && !req_final;
               fin_in = req_final;
               j_in = '0;
               last_j_in = (points_ff == qmcg_pkg::PTS_NONE) ? '0 : dens - DNW'(1);
               if (req_final) begin
                  points_in = qmcg_pkg::PTS_NONE;
               end else if (points_ff == qmcg_pkg::PTS_NONE) begin
                  points_in = qmcg_pkg::PTS_ONE;
               end else begin
                  points_in = qmcg_pkg::PTS_TWO;
               end
               if (req_final || (points_ff == qmcg_pkg::PTS_TWO)) begin
                  state_in = qmcg_pkg::ST_WEIGHT;
               end
            end
         end
         qmcg_pkg::ST_WEIGHT: begin
            cmd.weight_en = 1'b1;
            state_in = qmcg_pkg::ST_MULT;
         end
         qmcg_pkg::ST_MULT: begin
            cmd.mult_en = 1'b1;
            state_in = qmcg_pkg::ST_SUM;
         end
         qmcg_pkg::ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in = qmcg_pkg::ST_PREP;
         end
         qmcg_pkg::ST_PREP: begin
            cmd.prep_en = 1'b1;
            cnt_in = '0;
            state_in = qmcg_pkg::ST_DIV;
         end
         qmcg_pkg::ST_DIV: begin
            cmd.div_en = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = qmcg_pkg::ST_OUT;
            end
         end
         qmcg_pkg::ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.run_end = last_sample;
               cmd.path_end = last_sample && fin_ff;
               if (last_sample) begin
                  state_in = qmcg_pkg::ST_IDLE;
               end else begin
                  j_in = j_ff + DNW'(1);
                  state_in = qmcg_pkg::ST_WEIGHT;
               end
            end
         end
         default: begin
            state_in = qmcg_pkg::ST_IDLE;
         end
      endcase
   end

   `QMCG_ASSERT_IMPL(a_j_within_run, clock, reset, state_ff != qmcg_pkg::ST_IDLE, j_ff <= last_j_ff)
   `QMCG_ASSERT_IMPL(a_final_clears_path, clock, reset, (state_ff != qmcg_pkg::ST_IDLE) && fin_ff, points_ff == qmcg_pkg::PTS_NONE)
   `QMCG_ASSERT_IMPL(a_weight_entry, clock, reset, state_ff == qmcg_pkg::ST_WEIGHT, ($past(state_ff) == qmcg_pkg::ST_IDLE) || ($past(state_ff) == qmcg_pkg::ST_OUT))

endmodule

`default_nettype wire

// ===== hw/rtl/qmcg_dpath.sv =====
// datapath: path points, bezier weights, products, per-axis dividers, sample register
// depends on qmcg_pkg and the assertion macro header
`default_nettype none
`include "quadratic_midpoint_curve_gen_core_defines.svh"

module qmcg_dpath #(
   parameter int COORD_WIDTH = qmcg_pkg::COORD_WIDTH_DEF,
   parameter int MAX_DENSITY = qmcg_pkg::MAX_DENSITY_DEF
) (
   input  logic clock,
   input  logic reset,
   input  qmcg_pkg::qmcg_cmd_type cmd,
   output qmcg_pkg::qmcg_status_type status,
   input  logic [COORD_WIDTH-1:0] req_x,
   input  logic [COORD_WIDTH-1:0] req_y,
   input  logic rsp_ready,
   output logic rsp_valid,
   output logic [COORD_WIDTH-1:0] rsp_x,
   output logic [COORD_WIDTH-1:0] rsp_y,
   output logic rsp_run_end,
   output logic rsp_path_end
);

   localparam int CW = COORD_WIDTH;
   localparam int DW = $clog2(MAX_DENSITY + 1);
   localparam int WW = 2 * DW;
   localparam int NW = WW + CW + 1;

   function automatic logic [NW-1:0] weigh(input logic [CW-1:0] c, input logic [WW-1:0] w);
      logic [NW-1:0] ce;
      logic [NW-1:0] we;
      ce = {{(NW-CW){c[CW-1]}}, c};
      we = {{(NW-WW){1'b0}}, w};
      return ce * we;
   endfunction

   function automatic logic [CW-1:0] midpoint(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      logic [CW:0] t;
      s = {a[CW-1], a} + {b[CW-1], b};
      t = s + {{CW{1'b0}}, s[CW] & s[0]};
      return t[CW:1];
   endfunction

   logic [CW-1:0] prev_x_ff, prev_y_ff, start_x_ff, start_y_ff;
   logic [CW-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic line_ff;
   logic [WW-1:0] dd_ff;
   logic [WW-1:0] w0_ff, w1_ff, w2_ff;
   logic [NW-1:0] px0_ff, px1_ff, px2_ff, py0_ff, py1_ff, py2_ff;
   logic [NW-1:0] num_x_ff, num_y_ff;
   logic neg_x_ff, neg_y_ff;
   logic [WW-1:0] rem_x_ff, rem_y_ff;
   logic [CW-1:0] quo_x_ff, quo_y_ff;
   logic rsp_valid_ff;
   logic [CW-1:0] rsp_x_ff, rsp_y_ff;
   logic rsp_run_end_ff, rsp_path_end_ff;

   logic [CW-1:0] mid_x, mid_y;
   logic [WW-1:0] d_w, j_w, u_w, d_new;
   logic [WW-1:0] w0_in, w1_in, w2_in;
   logic [NW-1:0] mag_x, mag_y;
   logic [WW:0] trial_x, trial_y;
   logic ge_x, ge_y;
   logic [CW-1:0] res_x, res_y;

   assign mid_x = midpoint(prev_x_ff, req_x);
   assign mid_y = midpoint(prev_y_ff, req_y);

   // weights for sample j of the segment
   always_comb begin
      d_new = WW'(cmd.density[DW-1:0]);
      d_w = d_new;
      j_w = WW'(cmd.j[DW-1:0]);
      u_w = d_w - j_w;
      if (line_ff) begin
         w0_in = WW'(d_w * u_w);
         w1_in = WW'(d_w * j_w);
         w2_in = '0;
      end else begin
         w0_in = WW'(u_w * u_w);
         w1_in = WW'((u_w * j_w) << 1);
         w2_in = WW'(j_w * j_w);
      end
   end

   assign mag_x = num_x_ff[NW-1] ? -num_x_ff : num_x_ff;
   assign mag_y = num_y_ff[NW-1] ? -num_y_ff : num_y_ff;

   // one quotient bit per cycle on each axis
   assign trial_x = {rem_x_ff, quo_x_ff[CW-1]};
   assign trial_y = {rem_y_ff, quo_y_ff[CW-1]};
   assign ge_x = (trial_x >= {1'b0, dd_ff});
   assign ge_y = (trial_y >= {1'b0, dd_ff});

   assign res_x = neg_x_ff ? -quo_x_ff : quo_x_ff;
   assign res_y = neg_y_ff ? -quo_y_ff : quo_y_ff;

   // path points
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         start_x_ff <= '0;
         start_y_ff <= '0;
      end else if (cmd.start) begin
         prev_x_ff <= req_x;
         prev_y_ff <= req_y;
         if (cmd.start_from_input) begin
            start_x_ff <= req_x;
            start_y_ff <= req_y;
         end else if (cmd.start_from_mid) begin
            start_x_ff <= mid_x;
            start_y_ff <= mid_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ax_ff <= cmd.a_from_input ? req_x : start_x_ff;
         ay_ff <= cmd.a_from_input ? req_y : start_y_ff;
         bx_ff <= cmd.line ? req_x : prev_x_ff;
         by_ff <= cmd.line ? req_y : prev_y_ff;
         cx_ff <= cmd.c_from_input ? req_x : mid_x;
         cy_ff <= cmd.c_from_input ? req_y : mid_y;
         line_ff <= cmd.line;
         dd_ff <= WW'(d_new * d_new);
      end
      if (cmd.weight_en) begin
         w0_ff <= w0_in;
         w1_ff <= w1_in;
         w2_ff <= w2_in;
      end
      if (cmd.mult_en) begin
         px0_ff <= weigh(ax_ff, w0_ff);
         px1_ff <= weigh(bx_ff, w1_ff);
         px2_ff <= weigh(cx_ff, w2_ff);
         py0_ff <= weigh(ay_ff, w0_ff);
         py1_ff <= weigh(by_ff, w1_ff);
         py2_ff <= weigh(cy_ff, w2_ff);
      end
      if (cmd.sum_en) begin
         num_x_ff <= px0_ff + px1_ff + px2_ff;
         num_y_ff <= py0_ff + py1_ff + py2_ff;
      end
      if (cmd.prep_en) begin
         neg_x_ff <= num_x_ff[NW-1];
         neg_y_ff <= num_y_ff[NW-1];
         rem_x_ff <= mag_x[NW-2:CW];
         rem_y_ff <= mag_y[NW-2:CW];
         quo_x_ff <= mag_x[CW-1:0];
         quo_y_ff <= mag_y[CW-1:0];
      end
      if (cmd.div_en) begin
         rem_x_ff <= ge_x ? WW'(trial_x - {1'b0, dd_ff}) : trial_x[WW-1:0];
         rem_y_ff <= ge_y ? WW'(trial_y - {1'b0, dd_ff}) : trial_y[WW-1:0];
         quo_x_ff <= {quo_x_ff[CW-2:0], ge_x};
         quo_y_ff <= {quo_y_ff[CW-2:0], ge_y};
      end
      if (cmd.out_load) begin
         rsp_x_ff <= res_x;
         rsp_y_ff <= res_y;
         rsp_run_end_ff <= cmd.run_end;
         rsp_path_end_ff <= cmd.path_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_x = rsp_x_ff;
   assign rsp_y = rsp_y_ff;
   assign rsp_run_end = rsp_run_end_ff;
   assign rsp_path_end = rsp_path_end_ff;

   `QMCG_ASSERT_IMPL(a_rem_x_below_divisor, clock, reset, cmd.out_load, rem_x_ff < dd_ff)
   `QMCG_ASSERT_IMPL(a_rem_y_below_divisor, clock, reset, cmd.out_load, rem_y_ff < dd_ff)
   `QMCG_ASSERT_IMPL(a_path_end_is_run_end, clock, reset, rsp_valid_ff && rsp_path_end_ff, rsp_run_end_ff)

endmodule

`default_nettype wire

// ===== hw/rtl/quadratic_midpoint_curve_gen_core.sv =====
// top level of the quadratic midpoint curve generator
// depends on qmcg_pkg, the channel interfaces, qmcg_ctrl and qmcg_dpath
//
//   channel    role     payload
//   req_chan   sink     in_x, in_y, path_final
//   rsp_chan   source   out_x, out_y, run_end, path_end
//   csr_chan   sink     segment_density
//
// an item that emits nothing leaves the sequencer idle; each sample of an item runs
// weight, mult, sum, prep, div and out, radix-2 dividers (one per axis) setting the pace
// reset is synchronous; density returns to 10 and the path restarts
// a stalled rsp_chan holds the sample register and the sequencer waits on it
// the next item is taken while the last sample of the previous one still waits
`default_nettype none

module quadratic_midpoint_curve_gen_core #(
   parameter int COORD_WIDTH = qmcg_pkg::COORD_WIDTH_DEF,
   parameter int MAX_DENSITY = qmcg_pkg::MAX_DENSITY_DEF
) (
   input  logic clock,
   input  logic reset,
   qmcg_req_if.sink req_chan,
   qmcg_rsp_if.source rsp_chan,
   qmcg_csr_if.sink csr_chan
);

   qmcg_pkg::qmcg_cmd_type cmd;
   qmcg_pkg::qmcg_status_type status;
   logic [COORD_WIDTH-1:0] rsp_x, rsp_y;

   qmcg_ctrl #(
      .COORD_WIDTH (COORD_WIDTH),
      .MAX_DENSITY (MAX_DENSITY)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_final (req_chan.path_final),
      .req_ready (req_chan.ready),
      .csr_valid (csr_chan.valid),
      .csr_data  (csr_chan.segment_density),
      .csr_ready (csr_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   qmcg_dpath #(
      .COORD_WIDTH (COORD_WIDTH),
      .MAX_DENSITY (MAX_DENSITY)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_x        (req_chan.in_x),
      .req_y        (req_chan.in_y),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_x        (rsp_x),
      .rsp_y        (rsp_y),
      .rsp_run_end  (rsp_chan.run_end),
      .rsp_path_end (rsp_chan.path_end)
   );

   assign rsp_chan.out_x = rsp_x;
   assign rsp_chan.out_y = rsp_y;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking bench for quadratic_midpoint_curve_gen_core: directed table then random paths
// predicts curve samples per control point and checks rsp_chan in order
// depends on qmcg_pkg, qmcg_req_if, qmcg_rsp_if, qmcg_csr_if and the core rtl
module tb_top;

   localparam int CW = qmcg_pkg::COORD_WIDTH_DEF;
   localparam int MAX_D = qmcg_pkg::MAX_DENSITY_DEF;
   localparam int DNW = qmcg_pkg::DENSITY_WIDTH;
   localparam int IDLE_SETTLE = 32;
   localparam int END_DRAIN = 200;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int NUM_ROWS = 21;
   localparam int NUM_PHASES = 7;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic run_end;
      logic path_end;
   } curve_sample_type;

   typedef struct {
      int dens;
      int x;
      int y;
      bit fin;
      bit typed;
      int exp_x;
      int exp_y;
   } point_row_type;

   typedef struct {
      int dens_lo;
      int dens_hi;
      int send_pct;
      int recv_pct;
      int items;
   } phase_type;

   logic clock;
   logic reset;

   qmcg_req_if req_bus ();
   qmcg_rsp_if rsp_bus ();
   qmcg_csr_if csr_bus ();

   quadratic_midpoint_curve_gen_core dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   // dens -1 keeps the current density
   point_row_type point_rows [0:NUM_ROWS-1] = '{
      '{-1, 32767, -32768, 1'b1, 1'b1, 32767, -32768},
      '{-1, -32768, 32767, 1'b1, 1'b1, -32768, 32767},
      '{-1, 0, 0, 1'b0, 1'b0, 0, 0},
      '{-1, 1000, -1000, 1'b1, 1'b0, 0, 0},
      '{-1, -32768, -32768, 1'b0, 1'b0, 0, 0},
      '{-1, 32767, 32767, 1'b0, 1'b0, 0, 0},
      '{-1, -32768, 32767, 1'b1, 1'b0, 0, 0},
      '{1, 100, 200, 1'b0, 1'b0, 0, 0},
      '{-1, -300, 400, 1'b0, 1'b0, 0, 0},
      '{-1, 500, -600, 1'b0, 1'b0, 0, 0},
      '{-1, 700, 800, 1'b1, 1'b0, 0, 0},
      '{0, 5, 5, 1'b0, 1'b0, 0, 0},
      '{-1, -5, -5, 1'b1, 1'b0, 0, 0},
      '{-1, 7, -7, 1'b1, 1'b1, 7, -7},
      '{127, 32767, 32767, 1'b0, 1'b0, 0, 0},
      '{-1, -32768, -32768, 1'b0, 1'b0, 0, 0},
      '{-1, 32767, -32768, 1'b0, 1'b0, 0, 0},
      '{-1, 0, 0, 1'b1, 1'b0, 0, 0},
      '{64, -1, 1, 1'b0, 1'b0, 0, 0},
      '{-1, 1, -1, 1'b1, 1'b0, 0, 0},
      '{-1, 0, -32768, 1'b1, 1'b1, 0, -32768}
   };

   phase_type run_phases [0:NUM_PHASES-1] = '{
      '{1, 1, 0, 0, 20},
      '{2, 9, 51, 0, 30},
      '{64, 64, 0, 51, 8},
      '{2, 12, 16, 16, 25},
      '{0, 0, 51, 0, 20},
      '{127, 127, 0, 0, 6},
      '{1, 16, 0, 51, 30}
   };

   curve_sample_type expected_samples[$];
   int error_count = 0;
   int cycle_count = 0;
   int send_pct = 0;
   int recv_pct = 0;

   logic [DNW-1:0] density_shadow = qmcg_pkg::DENSITY_RESET;
   logic signed [CW-1:0] last_x = '0;
   logic signed [CW-1:0] last_y = '0;
   logic signed [CW-1:0] seg_x = '0;
   logic signed [CW-1:0] seg_y = '0;
   qmcg_pkg::qmcg_points_type pts = qmcg_pkg::PTS_NONE;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= 50)
         $display("mismatch on %s: got %0d, expected %0d", what, got, want);
   endtask

   function automatic longint active_density();
      if (density_shadow == 0)
         return 1;
      if (density_shadow > MAX_D)
         return MAX_D;
      return longint'(density_shadow);
   endfunction

   task automatic emit_segment(input longint ax, input longint ay, input longint bx,
                               input longint by, input longint cx, input longint cy,
                               input bit straight, input bit fin,
                               ref curve_sample_type out_q[$]);
      longint d;
      longint dd;
      longint u;
      longint j;
      longint vx;
      longint vy;
      curve_sample_type s;
      d = active_density();
      dd = d * d;
      for (j = 0; j < d; j++) begin
         u = d - j;
         if (straight) begin
            vx = (u * ax + j * bx) / d;
            vy = (u * ay + j * by) / d;
         end else begin
            vx = (u * u * ax + 2 * u * j * bx + j * j * cx) / dd;
            vy = (u * u * ay + 2 * u * j * by + j * j * cy) / dd;
         end
         s.x = vx[CW-1:0];
         s.y = vy[CW-1:0];
         s.run_end = (j == d - 1);
         s.path_end = (j == d - 1) && fin;
         out_q = {out_q, s};
      end
   endtask

   task automatic predict_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                                input bit fin, ref curve_sample_type out_q[$]);
      longint mx;
      longint my;
      curve_sample_type s;
      case (pts)
         qmcg_pkg::PTS_NONE: begin
            if (fin) begin
               s.x = x;
               s.y = y;
               s.run_end = 1'b1;
               s.path_end = 1'b1;
               out_q = {out_q, s};
            end else begin
               seg_x = x;
               seg_y = y;
               pts = qmcg_pkg::PTS_ONE;
            end
         end
         qmcg_pkg::PTS_ONE: begin
            if (fin) begin
               emit_segment(seg_x, seg_y, x, y, 0, 0, 1'b1, 1'b1, out_q);
               pts = qmcg_pkg::PTS_NONE;
            end else begin
               pts = qmcg_pkg::PTS_TWO;
            end
         end
         default: begin
            if (fin) begin
               emit_segment(seg_x, seg_y, last_x, last_y, x, y, 1'b0, 1'b1, out_q);
               pts = qmcg_pkg::PTS_NONE;
            end else begin
               mx = (longint'(last_x) + longint'(x)) / 2;
               my = (longint'(last_y) + longint'(y)) / 2;
               emit_segment(seg_x, seg_y, last_x, last_y, mx, my, 1'b0, 1'b0, out_q);
               seg_x = mx[CW-1:0];
               seg_y = my[CW-1:0];
            end
         end
      endcase
      last_x = x;
      last_y = y;
   endtask

   task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input bit fin, input bit typed, input int exp_x, input int exp_y);
      int gap;
      curve_sample_type produced[$];
      curve_sample_type typed_s;
      gap = 0;
      if (send_pct > 0)
         while ($urandom_range(99) < send_pct)
            gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.in_x <= x;
      req_bus.in_y <= y;
      req_bus.path_final <= fin;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predict_point(x, y, fin, produced);
      if (typed) begin
         typed_s.x = exp_x[CW-1:0];
         typed_s.y = exp_y[CW-1:0];
         typed_s.run_end = 1'b1;
         typed_s.path_end = 1'b1;
         expected_samples = {expected_samples, typed_s};
      end else begin
         foreach (produced[i])
            expected_samples = {expected_samples, produced[i]};
      end
   endtask

   task automatic write_density(input logic [DNW-1:0] value);
      req_bus.valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.segment_density <= value;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      csr_bus.valid <= 1'b0;
      density_shadow = value;
   endtask

   function automatic logic [CW-1:0] rand_coord();
      int small_val;
      small_val = $urandom_range(200);
      case ($urandom_range(9))
         0: return {1'b1, {(CW-1){1'b0}}};
         1: return {1'b0, {(CW-1){1'b1}}};
         2: return CW'(small_val - 100);
         default: return CW'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin : rsp_check
      curve_sample_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected sample x", rsp_bus.out_x, 0);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_bus.out_x !== want.x)
               report_mismatch("out_x", rsp_bus.out_x, want.x);
            if (rsp_bus.out_y !== want.y)
               report_mismatch("out_y", rsp_bus.out_y, want.y);
            if (rsp_bus.run_end !== want.run_end)
               report_mismatch("run_end", rsp_bus.run_end, want.run_end);
            if (rsp_bus.path_end !== want.path_end)
               report_mismatch("path_end", rsp_bus.path_end, want.path_end);
         end
      end
      rsp_bus.ready <= (recv_pct == 0) || ($urandom_range(99) >= recv_pct);
   end

   initial begin : stimulus
      int dens;
      int sent;
      int path_len;
      int pos;
      int pick;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.in_x <= '0;
      req_bus.in_y <= '0;
      req_bus.path_final <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.segment_density <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         if (point_rows[r].dens >= 0)
            write_density(point_rows[r].dens[DNW-1:0]);
         send_point(point_rows[r].x[CW-1:0], point_rows[r].y[CW-1:0], point_rows[r].fin,
                    point_rows[r].typed, point_rows[r].exp_x, point_rows[r].exp_y);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         dens = $urandom_range(run_phases[p].dens_hi, run_phases[p].dens_lo);
         write_density(dens[DNW-1:0]);
         send_pct = run_phases[p].send_pct;
         recv_pct = run_phases[p].recv_pct;
         sent = 0;
         while (sent < run_phases[p].items) begin
            pick = $urandom_range(99);
            if (pick < 8)
               path_len = 1;
            else if (pick < 20)
               path_len = 2;
            else
               path_len = $urandom_range(8, 3);
            for (pos = 0; pos < path_len && sent < run_phases[p].items; pos++) begin
               send_point(rand_coord(), rand_coord(), pos == path_len - 1, 1'b0, 0, 0);
               sent++;
            end
         end
      end

      req_bus.valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
      repeat (END_DRAIN) @(posedge clock);
      if (error_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

// ===== quadratic_midpoint_curve_gen_core.f =====
+incdir+hw/rtl
hw/rtl/qmcg_pkg.sv
hw/rtl/qmcg_req_if.sv
hw/rtl/qmcg_rsp_if.sv
hw/rtl/qmcg_csr_if.sv
hw/rtl/qmcg_ctrl.sv
hw/rtl/qmcg_dpath.sv
hw/rtl/quadratic_midpoint_curve_gen_core.sv
dv/tb_top.sv
